FILE: rtl/core/gqk_pkg.sv
// shared types, codes and helpers of the greedy quadratic knapsack core
`default_nettype none

package gqk_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 5;
    localparam int WGT_W   = 16;
    localparam int VAL_W   = 16;
    localparam int REL_W   = 16;
    localparam int TOTAL_W = 32;
    localparam int CAP_W   = 20;
    localparam int CNT_W   = 6;

    localparam logic [CMD_W-1:0] CMD_LOAD_ITEM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_REL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN       = 2'd2;

    localparam logic CFG_CAPACITY   = 1'b0;
    localparam logic CFG_ITEM_COUNT = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        column_index;
        logic [WGT_W-1:0]        weight;
        logic [VAL_W-1:0]        value;
        logic signed [REL_W-1:0] relation;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]          item_index;
        logic                      item_valid;
        logic signed [TOTAL_W-1:0] total_value;
        logic                      last;
    } res_t;

    // a zero weight is scored as one
    function automatic logic [WGT_W-1:0] eff_weight(input logic [WGT_W-1:0] w);
        logic [WGT_W-1:0] r;
        r = (w == '0) ? WGT_W'(1) : w;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gqk_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module gqk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/gqk_cmp.sv
// score comparator: cross products registered, strict greater-than after
`default_nettype none

module gqk_cmp #(
    parameter int SW = 23
) (
    input  wire logic                              clk,
    input  wire logic signed [SW-1:0]              score_a,
    input  wire logic [gqk_pkg::WGT_W-1:0]         weight_a,
    input  wire logic signed [SW-1:0]              score_b,
    input  wire logic [gqk_pkg::WGT_W-1:0]         weight_b,
    output logic                                   beats
);

    localparam int PW = SW + gqk_pkg::WGT_W + 1;

    logic signed [gqk_pkg::WGT_W:0] wa_s;
    logic signed [gqk_pkg::WGT_W:0] wb_s;
    logic signed [PW-1:0]           lhs_next;
    logic signed [PW-1:0]           rhs_next;
    logic signed [PW-1:0]           lhs_reg;
    logic signed [PW-1:0]           rhs_reg;

    always_comb
    begin
        wa_s     = $signed({1'b0, weight_a});
        wb_s     = $signed({1'b0, weight_b});
        lhs_next = PW'(score_a) * PW'(wb_s);
        rhs_next = PW'(score_b) * PW'(wa_s);
    end

    always_ff @(posedge clk)
    begin
        lhs_reg <= lhs_next;
        rhs_reg <= rhs_next;
    end

    assign beats = lhs_reg > rhs_reg;

endmodule

`default_nettype wire

FILE: rtl/core/greedy_quadratic_knapsack_core.sv
// greedy quadratic knapsack core: command decode, run sequencer and result register
//
//  channel | direction | handshake          | payload
//  cmd     | in        | cmd_valid/cmd_stall | gqk_pkg::cmd_t
//  res     | out       | res_valid/res_stall | gqk_pkg::res_t
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// load commands are accepted back to back while the core is idle
// a run scores each item as its value plus its relation row (one relation ram read a cycle),
// insertion-sorts the items by score per weight, tries them in order against the remaining
// capacity, streams the relation column of each accepted item and ends with a last result
// reset clears control state; table contents are undefined until loaded
// a full result register under res_stall holds the sequencer at its push or end step
`default_nettype none

module greedy_quadratic_knapsack_core #(
    parameter int MAX_ITEMS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    output logic                              cmd_stall,
    input  wire gqk_pkg::cmd_t                cmd,
    output logic                              res_valid,
    input  wire logic                         res_stall,
    output gqk_pkg::res_t                     res,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic                         cfg_index,
    input  wire logic [gqk_pkg::CAP_W-1:0]    cfg_data
);

    localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int RD  = MAX_ITEMS * MAX_ITEMS;
    localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
    localparam int SW  = IW + 18;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_SCORE  = 5'd1;
    localparam logic [4:0] ST_DRAIN  = 5'd2;
    localparam logic [4:0] ST_SLOAD  = 5'd3;
    localparam logic [4:0] ST_SLOAD2 = 5'd4;
    localparam logic [4:0] ST_SRDSW  = 5'd5;
    localparam logic [4:0] ST_SMUL   = 5'd6;
    localparam logic [4:0] ST_SCMP   = 5'd7;
    localparam logic [4:0] ST_SWR    = 5'd8;
    localparam logic [4:0] ST_PRDO   = 5'd9;
    localparam logic [4:0] ST_PRDW   = 5'd10;
    localparam logic [4:0] ST_PFIT   = 5'd11;
    localparam logic [4:0] ST_PREL   = 5'd12;
    localparam logic [4:0] ST_PDRAIN = 5'd13;
    localparam logic [4:0] ST_PPUSH  = 5'd14;
    localparam logic [4:0] ST_END    = 5'd15;

    function automatic logic [RAW-1:0] rel_addr(input logic [IW-1:0] r,
                                                 input logic [IW-1:0] c);
        logic [RAW-1:0] a;
        a = RAW'(r) * RAW'(MAX_ITEMS) + RAW'(c);
        return a;
    endfunction

    // control registers
    logic [4:0]                   state_reg, state_next;
    logic [gqk_pkg::CAP_W-1:0]    cap_reg, cap_next;
    logic [gqk_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                         rv_reg, rv_next;
    logic [MAX_ITEMS-1:0]         chosen_reg, chosen_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic                         res_valid_reg, res_valid_next;
    logic [gqk_pkg::CAP_W-1:0]    rem_reg, rem_next;
    logic [gqk_pkg::TOTAL_W-1:0]  total_reg, total_next;

    // datapath registers
    logic [CW-1:0]                n_reg, n_next;
    logic [CW-1:0]                i_reg, i_next;
    logic [CW-1:0]                j_reg, j_next;
    logic [CW-1:0]                k_reg, k_next;
    logic [IW-1:0]                o_reg, o_next;
    logic [IW-1:0]                it_reg, it_next;
    logic [IW-1:0]                rx_reg, rx_next;
    logic                         rfirst_reg, rfirst_next;
    logic                         rlast_reg, rlast_next;
    logic signed [SW-1:0]         si_reg, si_next;
    logic [gqk_pkg::WGT_W-1:0]    wi_reg, wi_next;
    logic signed [SW-1:0]         acc_reg, acc_next;
    gqk_pkg::res_t                pend_reg, pend_next;
    gqk_pkg::res_t                res_reg, res_next;

    // ram ports
    logic                         wv_we;
    logic [IW-1:0]                wv_waddr;
    logic [IW-1:0]                w_raddr, v_raddr;
    logic [gqk_pkg::WGT_W-1:0]    w_rdata;
    logic [gqk_pkg::VAL_W-1:0]    v_rdata;
    logic                         r_we;
    logic [RAW-1:0]               r_waddr, r_raddr;
    logic [gqk_pkg::REL_W-1:0]    r_rdata;
    logic                         s_we;
    logic [IW-1:0]                s_waddr, s_raddr;
    logic [SW-1:0]                s_wdata, s_rdata;
    logic                         o_we;
    logic [IW-1:0]                o_waddr, o_raddr;
    logic [IW-1:0]                o_wdata, o_rdata;

    logic                         beats;
    logic                         cmd_acc;
    logic                         out_free;
    logic                         row_ok, col_ok;
    logic [CW-1:0]                n_calc;
    logic [CW-1:0]                n_last;
    logic [CW-1:0]                k_less2;
    logic signed [SW-1:0]         sum;
    gqk_pkg::res_t                new_res;

    gqk_ram #(.WIDTH(gqk_pkg::WGT_W), .DEPTH(MAX_ITEMS)) u_weights (
        .clk(clk), .we(wv_we), .waddr(wv_waddr), .wdata(cmd.weight),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    gqk_ram #(.WIDTH(gqk_pkg::VAL_W), .DEPTH(MAX_ITEMS)) u_values (
        .clk(clk), .we(wv_we), .waddr(wv_waddr), .wdata(cmd.value),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    gqk_ram #(.WIDTH(gqk_pkg::REL_W), .DEPTH(RD)) u_relations (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(cmd.relation),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    gqk_ram #(.WIDTH(SW), .DEPTH(MAX_ITEMS)) u_scores (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    gqk_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_order (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata)
    );

    gqk_cmp #(.SW(SW)) u_cmp (
        .clk(clk),
        .score_a(si_reg),
        .weight_a(wi_reg),
        .score_b($signed(s_rdata)),
        .weight_b(gqk_pkg::eff_weight(w_rdata)),
        .beats(beats)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign row_ok    = ({2'b00, cmd.row_index} < 7'(MAX_ITEMS));
    assign col_ok    = ({2'b00, cmd.column_index} < 7'(MAX_ITEMS));
    assign n_last    = n_reg - CW'(1);
    assign k_less2   = k_reg - CW'(2);
    assign n_calc    = ({1'b0, cnt_reg} > 7'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : CW'(cnt_reg);

    always_comb
    begin
        new_res.item_index  = gqk_pkg::IDX_W'(it_reg);
        new_res.item_valid  = 1'b1;
        new_res.total_value = $signed(total_reg);
        new_res.last        = 1'b0;
        sum = (rfirst_reg ? SW'($signed({1'b0, v_rdata})) : acc_reg)
            + SW'($signed(r_rdata));
    end

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        cnt_next        = cnt_reg;
        rv_next         = 1'b0;
        chosen_next     = chosen_reg;
        pend_valid_next = pend_valid_reg;
        res_valid_next  = res_valid_reg;
        rem_next        = rem_reg;
        total_next      = total_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        o_next          = o_reg;
        it_next         = it_reg;
        rx_next         = rx_reg;
        rfirst_next     = 1'b0;
        rlast_next      = 1'b0;
        si_next         = si_reg;
        wi_next         = wi_reg;
        acc_next        = acc_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;

        wv_we    = 1'b0;
        wv_waddr = IW'(cmd.row_index);
        w_raddr  = i_reg[IW-1:0];
        v_raddr  = i_reg[IW-1:0];
        r_we     = 1'b0;
        r_waddr  = rel_addr(IW'(cmd.row_index), IW'(cmd.column_index));
        r_raddr  = '0;
        s_we     = 1'b0;
        s_waddr  = rx_reg;
        s_wdata  = sum;
        s_raddr  = i_reg[IW-1:0];
        o_we     = 1'b0;
        o_waddr  = k_reg[IW-1:0];
        o_wdata  = o_reg;
        o_raddr  = i_reg[IW-1:0];

        if (cfg_valid)
        begin
            unique case (cfg_index)
                gqk_pkg::CFG_CAPACITY:   cap_next = cfg_data;
                gqk_pkg::CFG_ITEM_COUNT: cnt_next = cfg_data[gqk_pkg::CNT_W-1:0];
                default:                 cap_next = cap_reg;
            endcase
        end

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        // relation data returning from the ram
        if (rv_reg)
        begin
            if (state_reg == ST_SCORE || state_reg == ST_DRAIN)
            begin
                acc_next = sum;
                s_we     = rlast_reg;
            end
            else if (chosen_reg[rx_reg])
            begin
                total_next = total_reg + gqk_pkg::TOTAL_W'($signed(r_rdata));
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    unique case (cmd.command)
                        gqk_pkg::CMD_LOAD_ITEM: wv_we = row_ok;
                        gqk_pkg::CMD_LOAD_REL:  r_we  = row_ok && col_ok;
                        gqk_pkg::CMD_RUN:
                        begin
                            n_next      = n_calc;
                            chosen_next = '0;
                            rem_next    = cap_reg;
                            total_next  = '0;
                            i_next      = '0;
                            j_next      = '0;
                            state_next  = (n_calc == '0) ? ST_END : ST_SCORE;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCORE:
            begin
                r_raddr     = rel_addr(i_reg[IW-1:0], j_reg[IW-1:0]);
                rv_next     = 1'b1;
                rfirst_next = (j_reg == '0);
                rlast_next  = (j_reg == n_last);
                rx_next     = i_reg[IW-1:0];
                if (j_reg == n_last)
                begin
                    j_next = '0;
                    if (i_reg == n_last)
                    begin
                        i_next     = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + CW'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            ST_DRAIN:  state_next = ST_SLOAD;
            ST_SLOAD:  state_next = ST_SLOAD2;
            ST_SLOAD2:
            begin
                si_next = $signed(s_rdata);
                wi_next = gqk_pkg::eff_weight(w_rdata);
                k_next  = i_reg;
                o_raddr = n_last[IW-1:0];
                if (i_reg == '0)
                begin
                    state_next = ST_SWR;
                end
                else
                begin
                    o_raddr    = IW'(i_reg - CW'(1));
                    state_next = ST_SRDSW;
                end
            end
            ST_SRDSW:
            begin
                o_next     = o_rdata;
                s_raddr    = o_rdata;
                w_raddr    = o_rdata;
                state_next = ST_SMUL;
            end
            ST_SMUL:   state_next = ST_SCMP;
            ST_SCMP:
            begin
                if (beats)
                begin
                    // shift the weaker item up one place
                    o_we   = 1'b1;
                    k_next = k_reg - CW'(1);
                    if (k_reg == CW'(1))
                    begin
                        state_next = ST_SWR;
                    end
                    else
                    begin
                        o_raddr    = k_less2[IW-1:0];
                        state_next = ST_SRDSW;
                    end
                end
                else
                begin
                    state_next = ST_SWR;
                end
            end
            ST_SWR:
            begin
                o_we    = 1'b1;
                o_wdata = i_reg[IW-1:0];
                if (i_reg == n_last)
                begin
                    i_next     = '0;
                    state_next = ST_PRDO;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_SLOAD;
                end
            end
            ST_PRDO:   state_next = ST_PRDW;
            ST_PRDW:
            begin
                it_next    = o_rdata;
                w_raddr    = o_rdata;
                v_raddr    = o_rdata;
                state_next = ST_PFIT;
            end
            ST_PFIT:
            begin
                if ({4'b0000, w_rdata} <= rem_reg)
                begin
                    rem_next            = rem_reg - gqk_pkg::CAP_W'(w_rdata);
                    total_next          = total_reg + gqk_pkg::TOTAL_W'(v_rdata);
                    chosen_next[it_reg] = 1'b1;
                    j_next              = '0;
                    state_next          = ST_PREL;
                end
                else if (i_reg == n_last)
                begin
                    state_next = ST_END;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_PRDO;
                end
            end
            ST_PREL:
            begin
                r_raddr    = rel_addr(j_reg[IW-1:0], it_reg);
                rv_next    = 1'b1;
                rlast_next = (j_reg == n_last);
                rx_next    = j_reg[IW-1:0];
                if (j_reg == n_last)
                begin
                    state_next = ST_PDRAIN;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            ST_PDRAIN: state_next = ST_PPUSH;
            ST_PPUSH:
            begin
                // the previous pick goes out only once a later one proves it is not last
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        res_next       = pend_reg;
                        res_valid_next = 1'b1;
                    end
                    pend_next       = new_res;
                    pend_valid_next = 1'b1;
                    if (i_reg == n_last)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = ST_PRDO;
                    end
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        res_next      = pend_reg;
                        res_next.last = 1'b1;
                    end
                    else
                    begin
                        res_next.item_index  = '0;
                        res_next.item_valid  = 1'b0;
                        res_next.total_value = '0;
                        res_next.last        = 1'b1;
                    end
                    res_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= '0;
            cnt_reg        <= '0;
            rv_reg         <= 1'b0;
            chosen_reg     <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            rem_reg        <= '0;
            total_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            cnt_reg        <= cnt_next;
            rv_reg         <= rv_next;
            chosen_reg     <= chosen_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            rem_reg        <= rem_next;
            total_reg      <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        o_reg      <= o_next;
        it_reg     <= it_next;
        rx_reg     <= rx_next;
        rfirst_reg <= rfirst_next;
        rlast_reg  <= rlast_next;
        si_reg     <= si_next;
        wi_reg     <= wi_next;
        acc_reg    <= acc_next;
        pend_reg   <= pend_next;
        res_reg    <= res_next;
    end

    a_rem_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (rem_reg <= cap_reg))
        else $error("remaining capacity above capacity");

    a_read_only_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> (state_reg == ST_SCORE || state_reg == ST_DRAIN ||
                    state_reg == ST_PREL || state_reg == ST_PDRAIN))
        else $error("relation read returned outside a streaming phase");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.item_valid) |-> (res_reg.last && res_reg.total_value == 0))
        else $error("empty result not final or not zero");

    a_pend_before_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRDO && i_reg != '0) |-> pend_valid_reg || !chosen_reg[it_reg] ||
            (chosen_reg == '0))
        else $error("picked item lost before push");

endmodule

`default_nettype wire

FILE: test/tb_greedy_quadratic_knapsack_core.sv
// testbench of the greedy quadratic knapsack core: directed and random command streams
`timescale 1ns / 100ps

module tb_greedy_quadratic_knapsack_core;

    localparam int NITEMS      = 32;
    localparam int CYCLE_LIMIT = 2000000;

    // command code with no function
    localparam logic [gqk_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          cmd_valid;
    logic                          cmd_stall;
    gqk_pkg::cmd_t                 cmd;
    logic                          res_valid;
    logic                          res_stall;
    gqk_pkg::res_t                 res;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic                          cfg_index;
    logic [gqk_pkg::CAP_W-1:0]     cfg_data;

    greedy_quadratic_knapsack_core #(.MAX_ITEMS(NITEMS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // commands waiting for the driver and packing results still to arrive
    gqk_pkg::cmd_t pending_cmds[$];
    gqk_pkg::res_t expected_picks[$];

    int  idle_pct;
    int  stall_pct;
    int  fail_count;
    int  cycle_count;
    bit  hold_request;
    bit  hold_used;
    int  hold_left;

    // predictor copy of the tables and registers
    logic [gqk_pkg::WGT_W-1:0]        tbl_weight[NITEMS];
    logic [gqk_pkg::VAL_W-1:0]        tbl_value[NITEMS];
    logic signed [gqk_pkg::REL_W-1:0] tbl_rel[NITEMS][NITEMS];
    logic [gqk_pkg::CAP_W-1:0]        knap_capacity;
    logic [gqk_pkg::CNT_W-1:0]        knap_count;

    // what the stimulus has loaded so far, so no run reads an unloaded entry
    bit item_loaded[NITEMS];
    bit rel_loaded[NITEMS][NITEMS];
    int items_sent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint eff_wt(input int i);
        return (tbl_weight[i] == '0) ? 64'd1 : longint'(tbl_weight[i]);
    endfunction

    task automatic predict_packing();
        int            n;
        int            score[NITEMS];
        int            rank[NITEMS];
        bit            picked[NITEMS];
        int            k;
        int            it;
        int            total;
        int            npicked;
        longint        acc;
        longint        room;
        gqk_pkg::res_t r;
        n = (knap_count > NITEMS) ? NITEMS : int'(knap_count);
        for (int i = 0; i < n; i++)
        begin
            score[i] = int'(tbl_value[i]);
            for (int j = 0; j < n; j++)
                score[i] += int'(tbl_rel[i][j]);
            picked[i] = 1'b0;
        end
        // stable insertion sort, higher score per weight first, exact cross multiplication
        for (int i = 0; i < n; i++)
        begin
            k = i;
            while (k > 0 && longint'(score[i]) * eff_wt(rank[k-1])
                            > longint'(score[rank[k-1]]) * eff_wt(i))
            begin
                rank[k] = rank[k-1];
                k--;
            end
            rank[k] = i;
        end
        room    = longint'(knap_capacity);
        total   = 0;
        npicked = 0;
        for (int i = 0; i < n; i++)
        begin
            it = rank[i];
            if (longint'(tbl_weight[it]) <= room)
            begin
                picked[it] = 1'b1;
                acc = longint'(total) + longint'(tbl_value[it]);
                for (int j = 0; j < n; j++)
                    if (picked[j])
                        acc += longint'(tbl_rel[j][it]);
                total = int'(acc[31:0]);
                room -= longint'(tbl_weight[it]);
                r.item_index  = gqk_pkg::IDX_W'(it);
                r.item_valid  = 1'b1;
                r.total_value = total;
                r.last        = 1'b0;
                expected_picks.insert(expected_picks.size(), r);
                npicked++;
            end
        end
        if (npicked == 0)
        begin
            r.item_index  = '0;
            r.item_valid  = 1'b0;
            r.total_value = '0;
            r.last        = 1'b1;
            expected_picks.insert(expected_picks.size(), r);
        end
        else
            expected_picks[expected_picks.size()-1].last = 1'b1;
    endtask

    task automatic apply_command(input gqk_pkg::cmd_t c);
        case (c.command)
            gqk_pkg::CMD_LOAD_ITEM:
            begin
                tbl_weight[c.row_index] = c.weight;
                tbl_value[c.row_index]  = c.value;
            end
            gqk_pkg::CMD_LOAD_REL:  tbl_rel[c.row_index][c.column_index] = c.relation;
            gqk_pkg::CMD_RUN:       predict_packing();
            default:                ;
        endcase
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else
        begin
            logic took;
            took = cmd_valid && !cmd_stall;
            if (took)
            begin
                apply_command(cmd);
                void'(pending_cmds.pop_front());
            end
            if (cmd_valid && !took)
                ;
            else if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                cmd_valid <= 1'b1;
                cmd       <= pending_cmds[0];
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // long hold-off of the receiver, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_request && !hold_used)
        begin
            hold_left <= 400;
            hold_used <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_left > 0)
            res_stall <= 1'b1;
        else
            res_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_picks.size() == 0)
            begin
                $error("result transaction with nothing expected: index %0d total %0d",
                       res.item_index, res.total_value);
                fail_count++;
            end
            else
            begin
                gqk_pkg::res_t e;
                e = expected_picks.pop_front();
                if (res.item_index !== e.item_index)
                begin
                    $error("item_index expected %0d actual %0d", e.item_index, res.item_index);
                    fail_count++;
                end
                if (res.item_valid !== e.item_valid)
                begin
                    $error("item_valid expected %0d actual %0d", e.item_valid, res.item_valid);
                    fail_count++;
                end
                if (res.total_value !== e.total_value)
                begin
                    $error("total_value expected %0d actual %0d",
                           e.total_value, res.total_value);
                    fail_count++;
                end
                if (res.last !== e.last)
                begin
                    $error("last expected %0d actual %0d", e.last, res.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("greedy_quadratic_knapsack_core verification failed");
            $finish;
        end
    end

    // stimulus helpers
    task automatic push_cmd(input gqk_pkg::cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
        items_sent++;
    endtask

    task automatic load_item(input int i, input int w, input int v);
        gqk_pkg::cmd_t c;
        c           = gqk_pkg::cmd_t'($urandom());
        c.command   = gqk_pkg::CMD_LOAD_ITEM;
        c.row_index = gqk_pkg::IDX_W'(i);
        c.weight    = gqk_pkg::WGT_W'(w);
        c.value     = gqk_pkg::VAL_W'(v);
        item_loaded[i] = 1'b1;
        push_cmd(c);
    endtask

    task automatic load_rel(input int r, input int col, input int x);
        gqk_pkg::cmd_t c;
        c              = gqk_pkg::cmd_t'({$urandom(), $urandom()});
        c.command      = gqk_pkg::CMD_LOAD_REL;
        c.row_index    = gqk_pkg::IDX_W'(r);
        c.column_index = gqk_pkg::IDX_W'(col);
        c.relation     = gqk_pkg::REL_W'(x);
        rel_loaded[r][col] = 1'b1;
        push_cmd(c);
    endtask

    task automatic push_run();
        gqk_pkg::cmd_t c;
        c         = gqk_pkg::cmd_t'({$urandom(), $urandom()});
        c.command = gqk_pkg::CMD_RUN;
        push_cmd(c);
    endtask

    task automatic push_unused();
        gqk_pkg::cmd_t c;
        c         = gqk_pkg::cmd_t'({$urandom(), $urandom()});
        c.command = CMD_SPARE;
        push_cmd(c);
    endtask

    function automatic int rand_weight();
        case ($urandom_range(3))
            0:       return $urandom_range(65535, 1);
            1:       return $urandom_range(400, 1);
            default: return $urandom_range(20, 1);
        endcase
    endfunction

    function automatic int rand_value();
        return ($urandom_range(1)) ? $urandom_range(65535) : $urandom_range(50);
    endfunction

    function automatic int rand_rel();
        case ($urandom_range(4))
            0:       return $urandom_range(65535) - 32768;
            1:       return ($urandom_range(1)) ? -32768 : 32767;
            default: return $urandom_range(40) - 20;
        endcase
    endfunction

    task automatic random_item(input int i);
        load_item(i, rand_weight(), rand_value());
    endtask

    task automatic fill_tables(input int n);
        for (int i = 0; i < n; i++)
            if (!item_loaded[i])
                random_item(i);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (!rel_loaded[i][j])
                    load_rel(i, j, rand_rel());
    endtask

    task automatic write_reg(input logic idx, input int data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= gqk_pkg::CAP_W'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == gqk_pkg::CFG_CAPACITY)
            knap_capacity = gqk_pkg::CAP_W'(data);
        else
            knap_count = gqk_pkg::CNT_W'(data);
    endtask

    task automatic settle();
        while (pending_cmds.size() > 0 || cmd_valid || expected_picks.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_mode(input int round);
        case ((round / 6) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 31; stall_pct = 31; end
        endcase
    endtask

    task automatic start_round(input int cap, input int n);
        write_reg(gqk_pkg::CFG_CAPACITY, cap);
        write_reg(gqk_pkg::CFG_ITEM_COUNT, n);
    endtask

    initial
    begin
        int n;
        int cap;
        int round;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = 1'b0;
        cfg_data      = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        fail_count    = 0;
        hold_request  = 1'b0;
        items_sent    = 0;
        knap_capacity = '0;
        knap_count    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty run: no items in use
        start_round(5, 0);
        push_run();
        settle();

        // extremes of weight and value, zero weight, extreme relations, unused command
        start_round(1048575, 4);
        load_item(0, 1, 65535);
        load_item(1, 65535, 0);
        load_item(2, 0, 7);
        load_item(3, 3, 3);
        load_rel(0, 0, 32767);
        load_rel(1, 2, -32768);
        load_rel(3, 31, 5);
        push_unused();
        fill_tables(4);
        push_run();
        settle();

        // no room: only the zero weight item goes in
        start_round(0, 4);
        push_run();
        settle();

        // equal score per weight, lower index first
        start_round(3, 3);
        load_item(0, 2, 10);
        load_item(1, 2, 10);
        load_item(2, 4, 20);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                load_rel(i, j, 0);
        push_run();
        settle();

        round = 0;
        while (items_sent < 395)
        begin
            set_mode(round);
            case ($urandom_range(9))
                0:       n = 0;
                1:       n = $urandom_range(10, 7);
                default: n = $urandom_range(6, 1);
            endcase
            case ($urandom_range(3))
                0:       cap = $urandom_range(1048575);
                1:       cap = ($urandom_range(1)) ? 1048575 : 0;
                default: cap = $urandom_range(60);
            endcase
            start_round(cap, n);
            if (round == 9)
                hold_request = 1'b1;
            repeat ((round == 9) ? 3 : 1)
            begin
                repeat ($urandom_range(3))
                    random_item($urandom_range(NITEMS - 1));
                if (n > 0)
                    repeat ($urandom_range(3))
                        load_rel($urandom_range(n - 1), $urandom_range(n - 1), rand_rel());
                if ($urandom_range(5) == 0)
                    load_rel($urandom_range(NITEMS - 1), $urandom_range(NITEMS - 1),
                             rand_rel());
                if ($urandom_range(6) == 0)
                    push_unused();
                fill_tables(n);
                push_run();
            end
            settle();
            round++;
        end

        if (fail_count == 0)
            $display("greedy_quadratic_knapsack_core verification clean");
        else
            $display("greedy_quadratic_knapsack_core verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/gqk_pkg.sv
rtl/core/gqk_ram.sv
rtl/core/gqk_cmp.sv
rtl/core/greedy_quadratic_knapsack_core.sv
test/tb_greedy_quadratic_knapsack_core.sv
